>>> src/gbk_pkg.sv
`timescale 1ns / 1ps

package gbk_pkg;

  // Screen limits: a row or column step beyond these clips the glyph
  localparam int unsigned SCREEN_WIDTH  = 480;
  localparam int unsigned SCREEN_HEIGHT = 800;

  // GBK code reduction constants
  localparam logic [7:0] CODE_HIGH_BASE = 8'h81;
  localparam logic [7:0] CODE_LOW_BASE  = 8'h40;
  localparam logic [7:0] CODE_LOW_SKIP  = 8'h41;
  localparam logic [7:0] CODE_LOW_GAP   = 8'h7F;
  localparam logic [7:0] CODES_PER_ROW  = 8'd190;

  // Glyph sizes
  localparam logic [7:0] SMALL_BYTES  = 8'd32;
  localparam logic [7:0] LARGE_BYTES  = 8'd128;
  localparam logic [9:0] SMALL_HEIGHT = 10'd16;
  localparam logic [9:0] LARGE_HEIGHT = 10'd32;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_BYTE  = 1'b1
  } mode_e;

  // All results of one input transaction: pixel writes for the set bits in
  // mask (MSB first, row = row + bit distance from MSB), then, if fin is set, one final result
  typedef struct packed {
    logic [7:0]  mask;
    logic        fin;
    kind_e       fin_kind;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [15:0] color;
    logic [21:0] offset;
    logic [7:0]  nbytes;
  } bundle_t;

endpackage

>>> src/gbk_glyph_rasterizer.sv
`timescale 1ns / 1ps

// Results of a transaction are registered in a two-entry result queue before they are offered.
// Throughput: one input transaction per cycle while the second result slot is free; a
// glyph byte yields up to eight pixel writes plus one final result, one per cycle while
// the result port is ready, and a start yields one fetch request.
// A two-entry result queue sets how far input can run ahead.
// Reset: asynchronous, active low; clears the glyph state and empties the result queue.
module gbk_glyph_rasterizer
  import gbk_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] code_high, [15:8] code_low, [16] large_font, [26:17] start_x,
  // [36:27] start_y, [52:37] ink_color, [60:53] glyph_byte, [63:61] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [21:0] font_offset, [29:22] fetch_bytes, [39:30] pixel_x, [49:40] pixel_y,
  // [65:50] pixel_color, [71:66] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  // Input field split
  logic [7:0]  in_code_high;
  logic [7:0]  in_code_low;
  logic        in_large;
  logic [9:0]  in_start_x;
  logic [9:0]  in_start_y;
  logic [15:0] in_color;
  logic [7:0]  in_byte;

  assign in_code_high = s_axis_tdata[7:0];
  assign in_code_low  = s_axis_tdata[15:8];
  assign in_large     = s_axis_tdata[16];
  assign in_start_x   = s_axis_tdata[26:17];
  assign in_start_y   = s_axis_tdata[36:27];
  assign in_color     = s_axis_tdata[52:37];
  assign in_byte      = s_axis_tdata[60:53];

  // Glyph state
  logic [9:0]  cur_col_q, cur_col_d;
  logic [9:0]  cur_row_q, cur_row_d;
  logic [9:0]  glyph_top_q, glyph_top_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic        big_glyph_q, big_glyph_d;
  logic [15:0] color_q, color_d;
  logic        active_q, active_d;

  // Result queue: slot0 is the head shown on the output
  bundle_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic    v0_q, v0_d, v1_q, v1_d;

  logic    in_acc;
  logic    out_acc;
  logic    push;
  bundle_t new_b;

  assign s_axis_tready = ~v1_q;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Start: reduce the code and compute the glyph offset
  logic [7:0]  hi_red;
  logic [7:0]  lo_red;
  logic [15:0] code_index;
  logic [21:0] start_offset;

  always_comb begin
    hi_red = in_code_high - CODE_HIGH_BASE;
    lo_red = (in_code_low < CODE_LOW_GAP) ? (in_code_low - CODE_LOW_BASE)
                                          : (in_code_low - CODE_LOW_SKIP);
    code_index   = ({8'd0, hi_red} * {8'd0, CODES_PER_ROW}) + {8'd0, lo_red};
    start_offset = in_large ? 22'({code_index, 7'd0}) : 22'({code_index, 5'd0});
  end

  // Byte: walk the column and find the first row step past the screen
  logic [10:0] row_inc [8];
  logic [7:0]  pix_mask;
  logic        row_clip;
  logic [9:0]  clip_row;
  logic [9:0]  row_end;
  logic [9:0]  height;
  logic [10:0] col_inc;
  logic        col_wrap;
  logic        col_clip;
  logic [7:0]  bytes_dec;

  always_comb begin
    row_clip = 1'b0;
    clip_row = cur_row_q;
    pix_mask = '0;
    for (int i = 0; i < 8; i++) begin
      row_inc[i] = {1'b0, cur_row_q} + 11'(i + 1);
      if (!row_clip) begin
        pix_mask[7-i] = in_byte[7-i];
        if (row_inc[i] > 11'(SCREEN_HEIGHT)) begin
          row_clip = 1'b1;
          clip_row = row_inc[i][9:0];
        end
      end
    end
    row_end   = row_inc[7][9:0];
    height    = big_glyph_q ? LARGE_HEIGHT : SMALL_HEIGHT;
    col_wrap  = (10'(row_end - glyph_top_q) == height);
    col_inc   = {1'b0, cur_col_q} + 11'd1;
    col_clip  = col_wrap && (col_inc > 11'(SCREEN_WIDTH));
    bytes_dec = bytes_left_q - 8'd1;
  end

  // Next glyph state and the result bundle of this transaction
  always_comb begin
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    glyph_top_d  = glyph_top_q;
    bytes_left_d = bytes_left_q;
    big_glyph_d  = big_glyph_q;
    color_d      = color_q;
    active_d     = active_q;
    push         = 1'b0;

    new_b          = '0;
    new_b.col      = cur_col_q;
    new_b.row      = cur_row_q;
    new_b.color    = color_q;
    new_b.fin_kind = KIND_DONE;

    if (in_acc) begin
      if (s_axis_tuser == MODE_START) begin
        cur_col_d      = in_start_x;
        cur_row_d      = in_start_y;
        glyph_top_d    = in_start_y;
        bytes_left_d   = in_large ? LARGE_BYTES : SMALL_BYTES;
        big_glyph_d    = in_large;
        color_d        = in_color;
        active_d       = 1'b1;
        new_b.fin      = 1'b1;
        new_b.fin_kind = KIND_FETCH;
        new_b.offset   = start_offset;
        new_b.nbytes   = in_large ? LARGE_BYTES : SMALL_BYTES;
        push           = 1'b1;
      end else if (active_q) begin
        new_b.mask = pix_mask;
        if (row_clip) begin
          cur_row_d      = clip_row;
          active_d       = 1'b0;
          new_b.fin      = 1'b1;
          new_b.fin_kind = KIND_ABORT;
        end else begin
          bytes_left_d = bytes_dec;
          cur_row_d    = col_wrap ? glyph_top_q : row_end;
          if (col_wrap) begin
            cur_col_d = col_inc[9:0];
          end
          if (col_clip) begin
            active_d       = 1'b0;
            new_b.fin      = 1'b1;
            new_b.fin_kind = KIND_ABORT;
          end else if (bytes_dec == 8'd0) begin
            active_d       = 1'b0;
            new_b.fin      = 1'b1;
            new_b.fin_kind = KIND_DONE;
          end
        end
        push = (|pix_mask) | new_b.fin;
      end
    end
  end

  // Head decode: pick the topmost pending pixel, else the final result
  logic       has_pix;
  logic [2:0] pix_sel;
  logic [7:0] mask_after;
  logic       head_last;
  kind_e      head_kind;

  always_comb begin
    has_pix    = 1'b0;
    pix_sel    = '0;
    mask_after = slot0_q.mask;
    for (int i = 0; i < 8; i++) begin
      if (!has_pix && slot0_q.mask[7-i]) begin
        has_pix = 1'b1;
        pix_sel = 3'(i);
        mask_after[7-i] = 1'b0;
      end
    end
    head_last = has_pix ? ((mask_after == 8'd0) && !slot0_q.fin) : 1'b1;
    head_kind = has_pix ? KIND_PIXEL : slot0_q.fin_kind;
  end

  assign out_acc = m_axis_tvalid & m_axis_tready;

  // Drive the result channel from the head slot
  always_comb begin
    m_axis_tvalid = v0_q;
    m_axis_tuser  = head_kind;
    m_axis_tlast  = head_last;
    m_axis_tdata  = '0;
    if (head_kind == KIND_PIXEL) begin
      m_axis_tdata[39:30] = slot0_q.col;
      m_axis_tdata[49:40] = slot0_q.row + {7'd0, pix_sel};
      m_axis_tdata[65:50] = slot0_q.color;
    end else if (head_kind == KIND_FETCH) begin
      m_axis_tdata[21:0]  = slot0_q.offset;
      m_axis_tdata[29:22] = slot0_q.nbytes;
    end
  end

  // Advance the queue: retire pixels, pop finished bundles, push new ones
  always_comb begin
    v0_d    = v0_q;
    v1_d    = v1_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (out_acc && !head_last) begin
      slot0_d.mask = mask_after;
    end
    if (out_acc && head_last) begin
      if (v1_q) begin
        slot0_d = slot1_q;
        v0_d    = 1'b1;
        slot1_d = new_b;
        v1_d    = push;
      end else begin
        slot0_d = new_b;
        v0_d    = push;
      end
    end else if (push) begin
      if (!v0_q) begin
        slot0_d = new_b;
        v0_d    = 1'b1;
      end else begin
        slot1_d = new_b;
        v1_d    = 1'b1;
      end
    end
  end

  // Control and glyph state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      glyph_top_q  <= '0;
      bytes_left_q <= '0;
      big_glyph_q  <= 1'b0;
      color_q      <= '0;
      active_q     <= 1'b0;
      v0_q         <= 1'b0;
      v1_q         <= 1'b0;
    end else begin
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      glyph_top_q  <= glyph_top_d;
      bytes_left_q <= bytes_left_d;
      big_glyph_q  <= big_glyph_d;
      color_q      <= color_d;
      active_q     <= active_d;
      v0_q         <= v0_d;
      v1_q         <= v1_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

`ifndef NO_ASSERTIONS
  // The second slot only fills behind a held head
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q)
    else $error("second result slot valid with empty head");

  // A held bundle always has a result left to deliver
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> ((|slot0_q.mask) || slot0_q.fin))
    else $error("head bundle holds no result");

  // Bitmap bytes only produce results while a glyph is in progress
  a_byte_needs_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (s_axis_tuser == MODE_BYTE)) |-> active_q)
    else $error("results from a byte with no glyph in progress");

  // A fetch request ends the results of its start transaction
  a_fetch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_FETCH)) |-> m_axis_tlast)
    else $error("fetch request not marked last");
`endif

endmodule

>>> tb/sv/tb_gbk_glyph_rasterizer.sv
`timescale 1ns / 1ps

module tb_gbk_glyph_rasterizer;
  import gbk_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 145;
  localparam int unsigned DRAIN_CYCLES  = 20;

  // One result as it leaves the block, unpacked into its fields
  typedef struct {
    kind_e       kind;
    logic [21:0] offset;
    logic [7:0]  nbytes;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [15:0] color;
    logic        last;
  } draw_op_t;

  // Tracks the glyph being drawn and queues the draw operations it must produce
  class glyph_scoreboard;
    draw_op_t    draw_ops[$];
    int unsigned errors;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned top_row;
    int unsigned bytes_to_go;
    logic        tall_font;
    logic [15:0] ink;
    logic        drawing;

    function new();
      errors      = 0;
      col_pos     = 0;
      row_pos     = 0;
      top_row     = 0;
      bytes_to_go = 0;
      tall_font   = 1'b0;
      ink         = '0;
      drawing     = 1'b0;
    endfunction

    function int unsigned outstanding();
      return draw_ops.size();
    endfunction

    function void add_op(kind_e kind, int unsigned offset, int unsigned nbytes,
                         int unsigned px, int unsigned py, logic [15:0] color);
      draw_op_t op;
      op.kind   = kind;
      op.offset = offset[21:0];
      op.nbytes = nbytes[7:0];
      op.px     = px[9:0];
      op.py     = py[9:0];
      op.color  = color;
      op.last   = 1'b0;
      draw_ops.push_back(op);
    endfunction

    // Work out the draw operations caused by one accepted input transaction
    function void rasterize_item(mode_e mode, logic [63:0] d);
      int unsigned first;
      int unsigned height;
      int unsigned count;
      int unsigned offset;
      logic [7:0]  code_hi;
      logic [7:0]  code_lo;
      logic [7:0]  bits;
      logic        clipped;
      first = draw_ops.size();
      if (mode == MODE_START) begin
        code_hi = d[7:0] - CODE_HIGH_BASE;
        code_lo = (d[15:8] < CODE_LOW_GAP) ? d[15:8] - CODE_LOW_BASE
                                           : d[15:8] - CODE_LOW_SKIP;
        count  = d[16] ? 32'(LARGE_BYTES) : 32'(SMALL_BYTES);
        offset = ((32'(code_hi) * 32'(CODES_PER_ROW) + 32'(code_lo)) * count)
                 & 32'h3F_FFFF;
        col_pos     = 32'(d[26:17]);
        row_pos     = 32'(d[36:27]);
        top_row     = row_pos;
        bytes_to_go = count;
        tall_font   = d[16];
        ink         = d[52:37];
        drawing     = 1'b1;
        add_op(KIND_FETCH, offset, count, 0, 0, '0);
      end else if (drawing) begin
        bits    = d[60:53];
        height  = tall_font ? 32'(LARGE_HEIGHT) : 32'(SMALL_HEIGHT);
        clipped = 1'b0;
        // Walk the byte from its MSB down the current column
        for (int i = 7; i >= 0 && !clipped; i--) begin
          if (bits[i]) begin
            add_op(KIND_PIXEL, 0, 0, col_pos, row_pos, ink);
          end
          row_pos++;
          if (row_pos > SCREEN_HEIGHT) begin
            row_pos &= 32'h3FF;
            drawing = 1'b0;
            clipped = 1'b1;
            add_op(KIND_ABORT, 0, 0, 0, 0, '0);
          end
        end
        if (!clipped) begin
          bytes_to_go = (bytes_to_go - 1) & 32'hFF;
          // Wrap to the top of the next column once the font height is covered
          if (((row_pos - top_row) & 32'h3FF) == height) begin
            row_pos = top_row;
            col_pos++;
            if (col_pos > SCREEN_WIDTH) begin
              col_pos &= 32'h3FF;
              drawing = 1'b0;
              clipped = 1'b1;
              add_op(KIND_ABORT, 0, 0, 0, 0, '0);
            end
          end
          if (!clipped && bytes_to_go == 0) begin
            drawing = 1'b0;
            add_op(KIND_DONE, 0, 0, 0, 0, '0);
          end
        end
      end
      if (draw_ops.size() > first) begin
        draw_ops[draw_ops.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
        report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
      end
    endtask

    // Compare one accepted result with the oldest queued draw operation
    task check_result(logic [1:0] kind, logic [71:0] d, logic last);
      draw_op_t want;
      if (draw_ops.size() == 0) begin
        report($sformatf("unexpected result: kind %0d data 0x%0h", kind, d));
      end else begin
        want = draw_ops.pop_front();
        compare_field("kind",        32'(kind),      32'(want.kind));
        compare_field("font_offset", 32'(d[21:0]),   32'(want.offset));
        compare_field("fetch_bytes", 32'(d[29:22]),  32'(want.nbytes));
        compare_field("pixel_x",     32'(d[39:30]),  32'(want.px));
        compare_field("pixel_y",     32'(d[49:40]),  32'(want.py));
        compare_field("pixel_color", 32'(d[65:50]),  32'(want.color));
        compare_field("last",        32'(last),      32'(want.last));
      end
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  glyph_scoreboard board = new();

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 1;
  int unsigned stall_span  = 0;
  int unsigned stall_style = 0;

  gbk_glyph_rasterizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Generate the clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // End the run at the cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gbk_glyph_rasterizer verification failed");
      $finish;
    end
  end

  // Stall the result side in spans of changing style
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_span  <= $urandom_range(20, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= (stall_span % 3 == 0);
      end
    endcase
  end

  // Check results before noting the input accepted on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        board.rasterize_item(mode_e'(s_axis_tuser), s_axis_tdata);
      end
    end
  end

  // Offer one transaction, hold it until accepted, then maybe pause the burst
  task automatic send_item(mode_e mode, logic [7:0] hi, logic [7:0] lo, logic big,
                           logic [9:0] x, logic [9:0] y, logic [15:0] color,
                           logic [7:0] glyph_byte);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, glyph_byte, color, y, x, big, lo, hi};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic start_glyph(logic [7:0] hi, logic [7:0] lo, logic big,
                             logic [9:0] x, logic [9:0] y, logic [15:0] color);
    send_item(MODE_START, hi, lo, big, x, y, color, 8'($urandom));
  endtask

  task automatic feed_byte(logic [7:0] glyph_byte);
    send_item(MODE_BYTE, 8'($urandom), 8'($urandom), 1'($urandom), 10'($urandom),
              10'($urandom), 16'($urandom), glyph_byte);
  endtask

  // Draw one glyph with random content, position and length
  task automatic random_glyph(logic force_full_large);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        big;
    logic [9:0]  x;
    logic [9:0]  y;
    int unsigned nbytes;
    int unsigned style;
    int unsigned place;
    logic [7:0]  b;
    big    = force_full_large || ($urandom_range(0, 5) == 0);
    nbytes = big ? 32'(LARGE_BYTES) : 32'(SMALL_BYTES);
    // Mostly legal codes, sometimes any byte value
    if ($urandom_range(0, 4) == 0) begin
      hi = 8'($urandom);
      lo = 8'($urandom);
    end else begin
      hi = 8'($urandom_range(129, 254));
      lo = 8'($urandom_range(64, 254));
    end
    // Mostly on screen, sometimes near an edge or anywhere
    place = force_full_large ? 0 : $urandom_range(0, 9);
    x = 10'($urandom_range(0, SCREEN_WIDTH - (big ? 32 : 16)));
    y = 10'($urandom_range(0, SCREEN_HEIGHT - (big ? 32 : 16)));
    if (place == 7) begin
      x = 10'($urandom_range(SCREEN_WIDTH - 20, SCREEN_WIDTH + 4));
    end else if (place == 8) begin
      y = 10'($urandom_range(SCREEN_HEIGHT - 30, SCREEN_HEIGHT + 4));
    end else if (place == 9) begin
      x = 10'($urandom);
      y = 10'($urandom);
    end
    // Cut the glyph short now and then; large ones are long, so mostly short
    if (!force_full_large && (big || $urandom_range(0, 4) == 0)) begin
      nbytes = $urandom_range(1, big ? 40 : nbytes - 1);
    end
    style = $urandom_range(0, 3);
    start_glyph(hi, lo, big, x, y, 16'($urandom));
    repeat (nbytes) begin
      case (style)
        0: b = 8'($urandom);
        1: b = 8'($urandom & $urandom);
        2: b = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
        default: b = 8'($urandom | $urandom);
      endcase
      feed_byte(b);
    end
  endtask

  initial begin
    int unsigned glyph_count;
    int unsigned directed_items;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Byte with no glyph in progress: dropped
    feed_byte(8'hFF);
    // Lowest codes at the origin, then a large glyph replaces it mid-flight
    start_glyph(8'h81, 8'h40, 1'b0, 10'd0, 10'd0, 16'hFFFF);
    feed_byte(8'hFF);
    feed_byte(8'h00);
    start_glyph(8'hFE, 8'hFE, 1'b1, 10'd100, 10'd200, 16'h0000);
    feed_byte(8'h80);
    feed_byte(8'h01);
    // Low byte either side of the gap in the code table
    start_glyph(8'hB0, 8'h7E, 1'b0, 10'd10, 10'd20, 16'hA5A5);
    feed_byte(8'hAA);
    start_glyph(8'hB0, 8'h7F, 1'b1, 10'd30, 10'd40, 16'h5A5A);
    feed_byte(8'h55);
    // Codes outside the table wrap
    start_glyph(8'h00, 8'h00, 1'b1, 10'd50, 10'd60, 16'h1111);
    start_glyph(8'hFF, 8'hFF, 1'b0, 10'd70, 10'd80, 16'h2222);
    // Start already off screen: one pixel, then a row clip; later byte dropped
    start_glyph(8'hC0, 8'h80, 1'b0, 10'd1023, 10'd1023, 16'h3C3C);
    feed_byte(8'h80);
    feed_byte(8'hFF);
    // Bottom edge: rows run past the screen height
    start_glyph(8'h90, 8'hA0, 1'b0, 10'd0, 10'd795, 16'h1234);
    feed_byte(8'hFF);
    // Right edge: the first column step clips
    start_glyph(8'h90, 8'hA1, 1'b0, 10'd480, 10'd0, 16'hF800);
    feed_byte(8'hC3);
    feed_byte(8'h3C);
    start_glyph(8'hA1, 8'hA1, 1'b0, 10'd1023, 10'd0, 16'h07E0);
    feed_byte(8'h0F);
    feed_byte(8'hF0);
    directed_items = items_sent;

    // Random glyph streams with stray bytes mixed in
    glyph_count = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) feed_byte(8'($urandom));
      end else begin
        random_glyph(glyph_count == 1);
        glyph_count++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain what is still owed, then allow for trailing results
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("gbk_glyph_rasterizer verification clean");
    end else begin
      $display("gbk_glyph_rasterizer verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/gbk_pkg.sv
src/gbk_glyph_rasterizer.sv
tb/sv/tb_gbk_glyph_rasterizer.sv
